FILE: rtl/hcbf_pkg.sv
`default_nettype none
package hcbf_pkg;

    localparam int BYTE_W = 8;
    localparam int CL_W = 24;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHUNKED_MODE   = 1'b0,
        CFG_CONTENT_LENGTH = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_EXT     = 3'd1,
        PH_DATA    = 3'd2,
        PH_TAIL    = 3'd3,
        PH_TRAILER = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SATURATED  = 2'd1,
        ST_LAST_CHUNK = 2'd2
    } t_status;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_F = 8'h66;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_F = 8'h46;
    localparam logic [7:0] LC_HEX_BIAS = CHAR_LC_A - 8'd10;
    localparam logic [7:0] UC_HEX_BIAS = CHAR_UC_A - 8'd10;
    localparam logic [15:0] CRLF = 16'h0D0A;
    localparam logic [31:0] CRLFCRLF = 32'h0D0A0D0A;
    localparam logic [1:0] CHUNK_TAIL_LEN = 2'd2;
    localparam logic [2:0] TRAILER_SHORT = 3'd2;
    localparam logic [2:0] TRAILER_FULL = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] body_byte;
        logic              is_hex;
        logic [3:0]        hex_val;
        logic              is_lf;
    } t_beat;

    typedef struct packed {
        t_phase  phase_out;
        t_status status;
        logic    message_done;
        logic    is_payload;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/hcbf_front.sv
`default_nettype none
module hcbf_front (
    input  wire logic [hcbf_pkg::BYTE_W-1:0] i_body_byte,
    output hcbf_pkg::t_beat                  o_beat
);
    import hcbf_pkg::*;

    always_comb begin
        o_beat.body_byte = i_body_byte;
        o_beat.is_lf = (i_body_byte == CHAR_LF);
        o_beat.is_hex = 1'b0;
        o_beat.hex_val = '0;
        priority if (i_body_byte >= CHAR_0 && i_body_byte <= CHAR_9) begin
            o_beat.is_hex = 1'b1;
            o_beat.hex_val = 4'(i_body_byte - CHAR_0);
        end else if (i_body_byte >= CHAR_LC_A && i_body_byte <= CHAR_LC_F) begin
            o_beat.is_hex = 1'b1;
            o_beat.hex_val = 4'(i_body_byte - LC_HEX_BIAS);
        end else if (i_body_byte >= CHAR_UC_A && i_body_byte <= CHAR_UC_F) begin
            o_beat.is_hex = 1'b1;
            o_beat.hex_val = 4'(i_body_byte - UC_HEX_BIAS);
        end else begin
            o_beat.is_hex = 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/hcbf_queue.sv
`default_nettype none
module hcbf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire hcbf_pkg::t_beat i_beat,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output hcbf_pkg::t_beat      o_beat
);
    import hcbf_pkg::*;

    t_beat      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_beat = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/hcbf_back.sv
`default_nettype none
module hcbf_back #(
    parameter int SIZE_BITS = 24
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_beat_valid,
    input  wire hcbf_pkg::t_beat           i_beat,
    output logic                           o_beat_pop,
    input  wire logic                      i_chunked_mode,
    input  wire logic [hcbf_pkg::CL_W-1:0] i_content_length,
    output logic                           o_result_valid,
    output hcbf_pkg::t_result              o_result,
    input  wire logic                      i_result_ready
);
    import hcbf_pkg::*;

    localparam int CMP_W = ((SIZE_BITS > CL_W) ? SIZE_BITS : CL_W) + 1;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_size_accum, n_size_accum;
    logic [SIZE_BITS-1:0] r_bytes_remaining, n_bytes_remaining;
    logic [SIZE_BITS-1:0] r_plain_count, n_plain_count;
    logic [31:0]          r_last_four, n_last_four;
    logic [2:0]           r_trailer_count, n_trailer_count;
    logic                 r_out_valid;
    t_result              r_result, n_result;

    logic [CMP_W-1:0]       plain_inc;
    logic [SIZE_BITS+3:0]   size_shift;
    logic [SIZE_BITS-1:0]   remain_dec;

    assign o_beat_pop = i_beat_valid && (!r_out_valid || i_result_ready);
    assign o_result_valid = r_out_valid;
    assign o_result = r_result;

    assign plain_inc = CMP_W'(r_plain_count) + CMP_W'(1);
    assign size_shift = {r_size_accum, 4'b0000} + (SIZE_BITS+4)'(i_beat.hex_val);
    assign remain_dec = r_bytes_remaining - SIZE_BITS'(1);

    always_comb begin
        n_phase = r_phase;
        n_size_accum = r_size_accum;
        n_bytes_remaining = r_bytes_remaining;
        n_plain_count = r_plain_count;
        n_last_four = r_last_four;
        n_trailer_count = r_trailer_count;
        n_result.is_payload = 1'b0;
        n_result.message_done = 1'b0;
        n_result.status = ST_OK;
        n_result.phase_out = r_phase;
        if (!i_chunked_mode) begin
            n_result.phase_out = PH_DATA;
            n_result.is_payload = (i_content_length != '0);
            if (plain_inc >= CMP_W'(i_content_length)) begin
                n_result.message_done = 1'b1;
                n_phase = PH_SIZE;
                n_size_accum = '0;
                n_bytes_remaining = '0;
                n_plain_count = '0;
                n_last_four = '0;
                n_trailer_count = '0;
            end else begin
                n_plain_count = plain_inc[SIZE_BITS-1:0];
            end
        end else begin
            unique case (r_phase)
                PH_EXT: begin
                    if (i_beat.is_lf) begin
                        if (r_size_accum == '0) begin
                            n_phase = PH_TRAILER;
                            n_last_four = '0;
                            n_trailer_count = '0;
                            n_result.status = ST_LAST_CHUNK;
                        end else begin
                            n_bytes_remaining = r_size_accum;
                            n_size_accum = '0;
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_result.is_payload = 1'b1;
                    n_bytes_remaining = remain_dec;
                    if (remain_dec == '0) begin
                        n_bytes_remaining = SIZE_BITS'(CHUNK_TAIL_LEN);
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    n_bytes_remaining = remain_dec;
                    if (remain_dec == '0) begin
                        n_phase = PH_SIZE;
                    end
                end
                PH_TRAILER: begin
                    n_result.status = ST_LAST_CHUNK;
                    n_last_four = {r_last_four[23:0], i_beat.body_byte};
                    if (r_trailer_count < TRAILER_FULL) begin
                        n_trailer_count = r_trailer_count + 3'd1;
                    end
                    if ((n_trailer_count == TRAILER_SHORT && n_last_four[15:0] == CRLF) ||
                        (n_trailer_count >= TRAILER_FULL && n_last_four == CRLFCRLF)) begin
                        n_result.message_done = 1'b1;
                        n_phase = PH_SIZE;
                        n_size_accum = '0;
                        n_bytes_remaining = '0;
                        n_plain_count = '0;
                        n_last_four = '0;
                        n_trailer_count = '0;
                    end
                end
                default: begin
                    n_result.phase_out = PH_SIZE;
                    n_phase = PH_SIZE;
                    if (i_beat.is_hex) begin
                        if (size_shift[SIZE_BITS+3:SIZE_BITS] != 4'b0000) begin
                            n_size_accum = SIZE_MAX;
                            n_result.status = ST_SATURATED;
                        end else begin
                            n_size_accum = size_shift[SIZE_BITS-1:0];
                        end
                    end else if (i_beat.is_lf) begin
                        if (r_size_accum == '0) begin
                            n_phase = PH_TRAILER;
                            n_last_four = '0;
                            n_trailer_count = '0;
                            n_result.status = ST_LAST_CHUNK;
                        end else begin
                            n_bytes_remaining = r_size_accum;
                            n_size_accum = '0;
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_phase = PH_EXT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_size_accum <= '0;
            r_bytes_remaining <= '0;
            r_plain_count <= '0;
            r_last_four <= '0;
            r_trailer_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_beat_pop) begin
                r_phase <= n_phase;
                r_size_accum <= n_size_accum;
                r_bytes_remaining <= n_bytes_remaining;
                r_plain_count <= n_plain_count;
                r_last_four <= n_last_four;
                r_trailer_count <= n_trailer_count;
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_beat_pop) begin
            r_result <= n_result;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/http_chunked_body_framer_unit.sv
`default_nettype none
// Frames an HTTP/1.1 message body one byte per beat. In chunked mode it parses the hex
// chunk size, skips extensions, flags chunk data bytes, skips the two bytes after each
// chunk and ends the message on the empty line or trailer after the zero-size chunk; in
// plain mode it ends the message after content_length bytes. Every input beat yields one
// result beat, and the unit sustains one beat per clock unless m_axis_tready stalls it.
// A result is registered: each byte passes through the two-entry input queue and then the
// framing stage, whose state register sets the rate. The user must write configuration
// only while idle; the unit itself does not enforce this.
module http_chunked_body_framer_unit #(
    parameter int SIZE_BITS = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [7:0]                       s_axis_tdata,  // body_byte[7:0]
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [7:0]                            m_axis_tdata,
    // is_payload[0], message_done[1], status[3:2], phase_out[6:4], zero[7]
    input  wire logic                             i_cfg_we,
    input  wire logic [hcbf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [hcbf_pkg::CL_W-1:0]        i_cfg_data
);
    import hcbf_pkg::*;

    logic            r_chunked_mode;
    logic [CL_W-1:0] r_content_length;
    t_beat           front_beat;
    t_beat           queue_beat;
    logic            queue_full;
    logic            queue_valid;
    logic            queue_pop;
    t_result         result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunked_mode <= 1'b1;
            r_content_length <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CHUNKED_MODE:   r_chunked_mode <= i_cfg_data[0];
                CFG_CONTENT_LENGTH: r_content_length <= i_cfg_data;
                default:            r_chunked_mode <= r_chunked_mode;
            endcase
        end
    end

    assign s_axis_tready = !queue_full;

    hcbf_front u_front (
        .i_body_byte (s_axis_tdata),
        .o_beat      (front_beat)
    );

    hcbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid && s_axis_tready),
        .i_beat  (front_beat),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_beat  (queue_beat)
    );

    hcbf_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_beat_valid     (queue_valid),
        .i_beat           (queue_beat),
        .o_beat_pop       (queue_pop),
        .i_chunked_mode   (r_chunked_mode),
        .i_content_length (r_content_length),
        .o_result_valid   (m_axis_tvalid),
        .o_result         (result),
        .i_result_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, result.phase_out, result.status,
                           result.message_done, result.is_payload};

endmodule
`default_nettype wire
